FILE: rtl/slgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slgr_pkg
// Shared types and constants for the static list group reverser.
// ----------------------------------------------------------------------------
package slgr_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned MAX_NODES_DEF   = 64;

  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LINK_W  = 11;
  localparam int unsigned GROUP_W = 7;
  localparam int unsigned CNT_W   = 7;

  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned RES_DEPTH  = 4;
  localparam int unsigned RES_FREE_W = $clog2(RES_DEPTH + 1);

  localparam logic [LINK_W-1:0] NULL_LINK = '1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_RUN,
    CMD_EMPTY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                  kind;
    logic [ADDR_W-1:0]          addr;
    logic signed [VALUE_W-1:0]  value;
    logic signed [LINK_W-1:0]   succ;
    logic [GROUP_W-1:0]         group;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]          addr;
    logic signed [VALUE_W-1:0]  value;
    logic signed [LINK_W-1:0]   succ;
    logic                       last;
    logic                       empty_res;
    logic                       trunc;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_EMIT,
    ST_FLUSH
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/static_list_group_reverser.sv
// A load word writes one node (value and successor) into the node table. A
// run word with a null head gives a single empty result. Any other run walks
// the list node by node, each step waiting on the registered read of the link
// table, then emits its n results at one per cycle while the result queue has
// room, through a three-stage order-buffer and value-table read pipe. Input
// and result queues decouple both sides, so words are taken while results wait.
// The node table has no reset and needs no clearing pass; entries must be
// written before a walk reaches them.
`default_nettype none
// ----------------------------------------------------------------------------
// static_list_group_reverser
// Linked-list walker; emits each full group of k nodes reversed, tail in order.
// ----------------------------------------------------------------------------
module static_list_group_reverser #(
  parameter int unsigned TABLE_DEPTH = slgr_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_NODES   = slgr_pkg::MAX_NODES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                kind_i,
  input  wire logic [slgr_pkg::ADDR_W-1:0]         node_address_i,
  input  wire logic                                head_is_null_i,
  input  wire logic signed [slgr_pkg::VALUE_W-1:0] node_value_i,
  input  wire logic signed [slgr_pkg::LINK_W-1:0]  successor_i,
  input  wire logic [slgr_pkg::GROUP_W-1:0]        group_size_i,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [slgr_pkg::ADDR_W-1:0]              out_address_o,
  output logic signed [slgr_pkg::VALUE_W-1:0]      out_value_o,
  output logic signed [slgr_pkg::LINK_W-1:0]       out_successor_o,
  output logic                                     last_o,
  output logic                                     empty_res_o,
  output logic                                     truncated_o
);
  import slgr_pkg::*;

  logic                    cmd_valid, cmd_pop, res_push, res_full;
  cmd_t                    cmd;
  res_t                    res_in, res_out;
  logic [$bits(res_t)-1:0] res_rd;
  logic [RES_FREE_W-1:0]   res_free;

  slgr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .node_address_i (node_address_i),
    .head_is_null_i (head_is_null_i),
    .node_value_i   (node_value_i),
    .successor_i    (successor_i),
    .group_size_i   (group_size_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  slgr_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_NODES   (MAX_NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_free_i  (res_free)
  );

  slgr_fifo #(
    .Width ($bits(res_t)),
    .Depth (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rd),
    .empty_o (empty),
    .free_o  (res_free)
  );

  assign res_out         = res_t'(res_rd);
  assign out_address_o   = res_out.addr;
  assign out_value_o     = res_out.value;
  assign out_successor_o = res_out.succ;
  assign last_o          = res_out.last && !res_full | res_out.last;
  assign empty_res_o     = res_out.empty_res;
  assign truncated_o     = res_out.trunc;

endmodule
`default_nettype wire

FILE: rtl/slgr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slgr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module slgr_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/slgr_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slgr_fifo
// Small register queue with full/empty flags and a free-slot count.
// ----------------------------------------------------------------------------
module slgr_fifo #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 4,
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW  = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  empty_o,
  output logic      [CntW-1:0]  free_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign free_o  = CntW'(Depth) - cnt_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/slgr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slgr_front
// Input side: classifies each word into a command and queues it.
// ----------------------------------------------------------------------------
module slgr_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                kind_i,
  input  wire logic [slgr_pkg::ADDR_W-1:0]         node_address_i,
  input  wire logic                                head_is_null_i,
  input  wire logic signed [slgr_pkg::VALUE_W-1:0] node_value_i,
  input  wire logic signed [slgr_pkg::LINK_W-1:0]  successor_i,
  input  wire logic [slgr_pkg::GROUP_W-1:0]        group_size_i,
  output logic                                     cmd_valid_o,
  output slgr_pkg::cmd_t                           cmd_o,
  input  wire logic                                cmd_pop_i
);
  import slgr_pkg::*;

  cmd_t                          cmd_in;
  logic [$bits(cmd_t)-1:0]       cmd_rd;
  logic                          cmd_empty;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_free;

  always_comb begin
    cmd_in.addr  = node_address_i;
    cmd_in.value = node_value_i;
    cmd_in.succ  = successor_i;
    // zero group size behaves as one
    cmd_in.group = (group_size_i == '0) ? GROUP_W'(1) : group_size_i;
    if (!kind_i) begin
      cmd_in.kind = CMD_LOAD;
    end else if (head_is_null_i) begin
      cmd_in.kind = CMD_EMPTY;
    end else begin
      cmd_in.kind = CMD_RUN;
    end
  end

  slgr_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_rd),
    .empty_o (cmd_empty),
    .free_o  (cmd_free)
  );

  assign cmd_valid_o = !cmd_empty && (cmd_free != '1);
  assign cmd_o       = cmd_t'(cmd_rd);

endmodule
`default_nettype wire

FILE: rtl/slgr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slgr_back
// Execution side: node table writes, list walk and grouped emission.
// ----------------------------------------------------------------------------
module slgr_back #(
  parameter int unsigned TABLE_DEPTH = slgr_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_NODES   = slgr_pkg::MAX_NODES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cmd_valid_i,
  input  wire slgr_pkg::cmd_t                     cmd_i,
  output logic                                    cmd_pop_o,
  output logic                                    res_push_o,
  output slgr_pkg::res_t                          res_o,
  input  wire logic [slgr_pkg::RES_FREE_W-1:0]    res_free_i
);
  import slgr_pkg::*;

  localparam int unsigned TabAw = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned OrdAw = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  function automatic logic [TabAw-1:0] tab_addr(input logic [ADDR_W-1:0] a);
    logic [16:0] ax;
    ax = {7'b0, a};
    return ax[TabAw-1:0];
  endfunction

  function automatic logic in_table(input logic [ADDR_W-1:0] a);
    return {7'b0, a} < 17'(TABLE_DEPTH);
  endfunction

  state_e                    state_q, state_d;
  logic [ADDR_W-1:0]         p_q, p_d;
  logic [CNT_W-1:0]          n_q, n_d, j_q, j_d;
  logic [GROUP_W-1:0]        k_q, k_d, r_q, r_d;
  logic [7:0]                gb_q, gb_d;
  logic                      trunc_q, trunc_d;
  logic                      inr_q, inr_d;
  logic                      s1_v_q, s2_v_q, s2_inr_q;
  logic [ADDR_W-1:0]         s2_addr_q;
  logic                      pend_v_q, pend_v_d;
  logic [ADDR_W-1:0]         pend_addr_q, pend_addr_d;
  logic signed [VALUE_W-1:0] pend_val_q, pend_val_d;

  logic                      tab_we, ob_we, issue;
  logic [VALUE_W-1:0]        val_rdata;
  logic [LINK_W-1:0]         link_rdata, link_now;
  logic [ADDR_W-1:0]         ob_rdata;
  logic [7:0]                grp_end, idx;
  logic                      grp_full;
  logic [RES_FREE_W-1:0]     inflight;
  logic signed [VALUE_W-1:0] s2_val;

  slgr_ram #(.Width(VALUE_W), .Depth(TABLE_DEPTH)) u_value_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_addr(cmd_i.addr)),
    .wdata_i (cmd_i.value),
    .raddr_i (tab_addr(ob_rdata)),
    .rdata_o (val_rdata)
  );

  slgr_ram #(.Width(LINK_W), .Depth(TABLE_DEPTH)) u_link_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_addr(cmd_i.addr)),
    .wdata_i (cmd_i.succ),
    .raddr_i (tab_addr(p_q)),
    .rdata_o (link_rdata)
  );

  slgr_ram #(.Width(ADDR_W), .Depth(MAX_NODES)) u_order_buf (
    .clk_i   (clk_i),
    .we_i    (ob_we),
    .waddr_i (n_q[OrdAw-1:0]),
    .wdata_i (p_q),
    .raddr_i (idx[OrdAw-1:0]),
    .rdata_o (ob_rdata)
  );

  // emission index: complete groups reversed, tail in order
  assign grp_end  = gb_q + 8'(k_q);
  assign grp_full = (grp_end <= {1'b0, n_q});
  assign idx      = grp_full ? (grp_end - 8'd1 - 8'(r_q)) : (gb_q + 8'(r_q));
  assign inflight = RES_FREE_W'(s1_v_q) + RES_FREE_W'(s2_v_q);
  assign link_now = inr_q ? link_rdata : NULL_LINK;
  assign s2_val   = s2_inr_q ? signed'(val_rdata) : '0;

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    n_d         = n_q;
    j_d         = j_q;
    k_d         = k_q;
    r_d         = r_q;
    gb_d        = gb_q;
    trunc_d     = trunc_q;
    inr_d       = inr_q;
    pend_v_d    = pend_v_q;
    pend_addr_d = pend_addr_q;
    pend_val_d  = pend_val_q;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o       = '0;
    tab_we      = 1'b0;
    ob_we       = 1'b0;
    issue       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_LOAD: begin
              cmd_pop_o = 1'b1;
              tab_we    = in_table(cmd_i.addr);
            end
            CMD_RUN: begin
              cmd_pop_o = 1'b1;
              p_d       = cmd_i.addr;
              k_d       = cmd_i.group;
              n_d       = '0;
              j_d       = '0;
              r_d       = '0;
              gb_d      = '0;
              trunc_d   = 1'b0;
              pend_v_d  = 1'b0;
              state_d   = ST_WALK_RD;
            end
            CMD_EMPTY: begin
              if (res_free_i != '0) begin
                cmd_pop_o       = 1'b1;
                res_push_o      = 1'b1;
                res_o.last      = 1'b1;
                res_o.empty_res = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK_RD: begin
        ob_we   = 1'b1;
        inr_d   = in_table(p_q);
        n_d     = n_q + CNT_W'(1);
        state_d = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (link_now[LINK_W-1]) begin
          state_d = ST_EMIT;
        end else if (n_q == CNT_W'(MAX_NODES)) begin
          trunc_d = 1'b1;
          state_d = ST_EMIT;
        end else begin
          p_d     = link_now[ADDR_W-1:0];
          state_d = ST_WALK_RD;
        end
      end
      ST_EMIT: begin
        if (j_q == n_q) begin
          if (!s1_v_q && !s2_v_q) begin
            state_d = ST_FLUSH;
          end
        end else if (res_free_i > inflight) begin
          issue = 1'b1;
          j_d   = j_q + CNT_W'(1);
          if (grp_full && (r_q == k_q - GROUP_W'(1))) begin
            gb_d = grp_end;
            r_d  = '0;
          end else begin
            r_d  = r_q + GROUP_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (res_free_i != '0) begin
          res_push_o  = 1'b1;
          res_o.addr  = pend_addr_q;
          res_o.value = pend_val_q;
          res_o.succ  = NULL_LINK;
          res_o.last  = 1'b1;
          res_o.trunc = trunc_q;
          pend_v_d    = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // node leaving the read pipe releases the one before it
    if (s2_v_q) begin
      if (pend_v_q) begin
        res_push_o  = 1'b1;
        res_o.addr  = pend_addr_q;
        res_o.value = pend_val_q;
        res_o.succ  = signed'({1'b0, s2_addr_q});
        res_o.trunc = trunc_q;
      end
      pend_v_d    = 1'b1;
      pend_addr_d = s2_addr_q;
      pend_val_d  = s2_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      pend_v_q <= 1'b0;
      n_q      <= '0;
      j_q      <= '0;
    end else begin
      state_q  <= state_d;
      s1_v_q   <= issue;
      s2_v_q   <= s1_v_q;
      pend_v_q <= pend_v_d;
      n_q      <= n_d;
      j_q      <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    k_q         <= k_d;
    r_q         <= r_d;
    gb_q        <= gb_d;
    trunc_q     <= trunc_d;
    inr_q       <= inr_d;
    s2_addr_q   <= ob_rdata;
    s2_inr_q    <= in_table(ob_rdata);
    pend_addr_q <= pend_addr_d;
    pend_val_q  <= pend_val_d;
  end

endmodule
`default_nettype wire

FILE: rtl/slgr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slgr_checker
// Port-level checks on result words of the group reverser.
// ----------------------------------------------------------------------------
module slgr_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                push,
  input wire logic                                full,
  input wire logic                                empty,
  input wire logic                                pop,
  input wire logic [slgr_pkg::ADDR_W-1:0]         out_address_o,
  input wire logic signed [slgr_pkg::VALUE_W-1:0] out_value_o,
  input wire logic signed [slgr_pkg::LINK_W-1:0]  out_successor_o,
  input wire logic                                last_o,
  input wire logic                                empty_res_o,
  input wire logic                                truncated_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_address_o) && $stable(last_o)))
    else $error("result word changed while stalled");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && empty_res_o) |-> (last_o && out_address_o == '0 &&
                                 out_value_o == '0 && out_successor_o == '0 &&
                                 !truncated_o))
    else $error("empty-list word malformed");

  a_last_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o && !empty_res_o) |-> (out_successor_o == '1))
    else $error("final word lacks null successor");

  a_mid_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_o) |-> (!out_successor_o[slgr_pkg::LINK_W-1] && !empty_res_o))
    else $error("non-final word has null successor");

  a_trunc_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) ##1 !empty |-> (truncated_o == $past(truncated_o)))
    else $error("truncated flag changed within a run");

endmodule

bind static_list_group_reverser slgr_checker u_slgr_checker (.*);
`default_nettype wire

FILE: test/static_list_group_reverser_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// static_list_group_reverser_tb
// Self-checking bench for the linked-list group reverser. Node loads and
// reversal runs go in through the input queue. A predictor in the bench keeps
// its own copy of the node table and works out every result word of each run.
// The run starts with directed cases: empty list, single node, group sizes
// around the list length, negative successors and a looping list. Random
// lists with random group sizes and random load and run noise follow. Both
// sides idle in random bursts, except in the last stretch of the run.
// ----------------------------------------------------------------------------
module static_list_group_reverser_tb;
  import slgr_pkg::*;

  localparam int          MAX_NODES      = MAX_NODES_DEF;
  localparam int          ITEM_TARGET    = 420;
  localparam int          QUIET_ITEMS    = 80;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          TAIL_CYCLES    = 250;
  localparam logic        KIND_LOAD      = 1'b0;
  localparam logic        KIND_RUN       = 1'b1;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      push = 1'b0;
  logic                      full;
  logic                      kind_i = KIND_LOAD;
  logic [ADDR_W-1:0]         node_address_i = '0;
  logic                      head_is_null_i = 1'b0;
  logic signed [VALUE_W-1:0] node_value_i = '0;
  logic signed [LINK_W-1:0]  successor_i = '0;
  logic [GROUP_W-1:0]        group_size_i = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [ADDR_W-1:0]         out_address_o;
  logic signed [VALUE_W-1:0] out_value_o;
  logic signed [LINK_W-1:0]  out_successor_o;
  logic                      last_o;
  logic                      empty_res_o;
  logic                      truncated_o;

  logic signed [VALUE_W-1:0] node_value_mem [TABLE_DEPTH_DEF];
  logic [LINK_W-1:0]         node_link_mem [TABLE_DEPTH_DEF];
  bit                        node_written [TABLE_DEPTH_DEF];
  logic [ADDR_W-1:0]         written_addrs [$];
  res_t                      expected_words [$];

  bit          gaps_on = 1'b1;
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned pop_hold = 0;

  static_list_group_reverser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .kind_i          (kind_i),
    .node_address_i  (node_address_i),
    .head_is_null_i  (head_is_null_i),
    .node_value_i    (node_value_i),
    .successor_i     (successor_i),
    .group_size_i    (group_size_i),
    .empty           (empty),
    .pop             (pop),
    .out_address_o   (out_address_o),
    .out_value_o     (out_value_o),
    .out_successor_o (out_successor_o),
    .last_o          (last_o),
    .empty_res_o     (empty_res_o),
    .truncated_o     (truncated_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // true if a walk from head only touches written entries, including the
  // entry after the last one taken on a truncated walk
  function automatic bit walk_stays_written(logic [ADDR_W-1:0] head);
    logic [ADDR_W-1:0] p;
    int                n;
    p = head;
    for (n = 0; n < MAX_NODES; n++) begin
      if (!node_written[p]) return 1'b0;
      if (node_link_mem[p][LINK_W-1]) return 1'b1;
      p = node_link_mem[p][ADDR_W-1:0];
    end
    return node_written[p];
  endfunction

  function automatic void predict_reordered_list(logic [ADDR_W-1:0] head, logic head_null,
                                                 logic [GROUP_W-1:0] group);
    logic [ADDR_W-1:0] visit [MAX_NODES];
    logic [ADDR_W-1:0] emit_order [MAX_NODES];
    logic [ADDR_W-1:0] p;
    int                n;
    int                k;
    int                m;
    int                g;
    int                j;
    bit                trunc;
    res_t              word;
    word = '0;
    if (head_null) begin
      word.last      = 1'b1;
      word.empty_res = 1'b1;
      expected_words = {expected_words, word};
      return;
    end
    n     = 0;
    p     = head;
    trunc = 1'b0;
    while (1) begin
      if (n >= MAX_NODES) begin
        trunc = 1'b1;
        break;
      end
      visit[n] = p;
      n++;
      if (node_link_mem[p][LINK_W-1]) break;
      p = node_link_mem[p][ADDR_W-1:0];
    end
    k = (group == '0) ? 1 : int'(group);
    m = 0;
    for (g = 0; g < n / k; g++) begin
      for (j = 0; j < k; j++) begin
        emit_order[m] = visit[g * k + k - 1 - j];
        m++;
      end
    end
    for (j = (n / k) * k; j < n; j++) begin
      emit_order[m] = visit[j];
      m++;
    end
    for (j = 0; j < n; j++) begin
      word.addr      = emit_order[j];
      word.value     = node_value_mem[emit_order[j]];
      word.succ      = (j + 1 < n) ? {1'b0, emit_order[j + 1]} : NULL_LINK;
      word.last      = (j + 1 == n);
      word.empty_res = 1'b0;
      word.trunc     = trunc;
      expected_words = {expected_words, word};
    end
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_word(logic kind, logic [ADDR_W-1:0] addr, logic head_null,
                           logic signed [VALUE_W-1:0] value, logic signed [LINK_W-1:0] succ,
                           logic [GROUP_W-1:0] group);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    push           <= 1'b1;
    kind_i         <= kind;
    node_address_i <= addr;
    head_is_null_i <= head_null;
    node_value_i   <= value;
    successor_i    <= succ;
    group_size_i   <= group;
    do @(posedge clk_i); while (full);
    if (kind == KIND_LOAD) begin
      node_value_mem[addr] = value;
      node_link_mem[addr]  = succ;
      if (!node_written[addr]) written_addrs = {written_addrs, addr};
      node_written[addr] = 1'b1;
    end else begin
      predict_reordered_list(addr, head_null, group);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_node(logic [ADDR_W-1:0] addr, logic signed [VALUE_W-1:0] value,
                           logic signed [LINK_W-1:0] succ);
    push_word(KIND_LOAD, addr, 1'($urandom_range(0, 1)), value, succ,
              GROUP_W'($urandom_range(0, 127)));
  endtask

  task automatic run_list(logic [ADDR_W-1:0] head, logic head_null, logic [GROUP_W-1:0] group);
    push_word(KIND_RUN, head, head_null, VALUE_W'($urandom()),
              LINK_W'($urandom_range(0, 2047)), group);
  endtask

  task automatic test_empty_list();
    run_list(10'h3FF, 1'b1, 7'd0);
    run_list(10'h000, 1'b1, 7'h7F);
  endtask

  task automatic test_single_node();
    load_node(10'h000, 32'sh7FFF_FFFF, -11'sd1);
    run_list(10'h000, 1'b0, 7'd1);
    run_list(10'h000, 1'b0, 7'd64);
  endtask

  task automatic test_group_reversal();
    load_node(10'h3FF, 32'sh8000_0000, 11'sd512);
    load_node(10'd512, -32'sd1, 11'sd5);
    load_node(10'd5, 32'sd0, 11'sd700);
    load_node(10'd700, 32'sd1, 11'sd1);
    load_node(10'd1, 32'sh5555_5555, -11'sd1);
    run_list(10'h3FF, 1'b0, 7'd2);
    run_list(10'h3FF, 1'b0, 7'd3);
    run_list(10'h3FF, 1'b0, 7'd5);
    run_list(10'h3FF, 1'b0, 7'd0);
    run_list(10'h3FF, 1'b0, 7'h7F);
  endtask

  task automatic test_negative_successor();
    load_node(10'd300, 32'sd12345, -11'sd1024);
    load_node(10'd301, -32'sd7, -11'sd2);
    load_node(10'd302, 32'sh2AAA_AAAA, 11'sd301);
    run_list(10'd300, 1'b0, 7'd1);
    run_list(10'd302, 1'b0, 7'd2);
  endtask

  task automatic test_walk_limit();
    load_node(10'd20, 32'sd20, 11'sd21);
    load_node(10'd21, 32'sd21, 11'sd20);
    run_list(10'd20, 1'b0, 7'd3);
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0]        addrs [72];
    bit                       used [TABLE_DEPTH_DEF];
    logic signed [LINK_W-1:0] succ;
    logic [ADDR_W-1:0]        a;
    logic [GROUP_W-1:0]       k;
    int                       len;
    int                       i;
    int                       runs;
    int                       neg;
    int unsigned              choice;
    bit                       loop_back;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent + QUIET_ITEMS >= ITEM_TARGET) gaps_on = 1'b0;
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        len       = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
        loop_back = ($urandom_range(0, 9) == 0);
        used      = '{default: 1'b0};
        for (i = 0; i < len; i++) begin
          do a = ADDR_W'($urandom_range(0, 1023)); while (used[a]);
          used[a]  = 1'b1;
          addrs[i] = a;
        end
        for (i = 0; i < len; i++) begin
          if (i + 1 < len) begin
            succ = {1'b0, addrs[i + 1]};
          end else if (loop_back) begin
            succ = {1'b0, addrs[$urandom_range(0, len - 1)]};
          end else if ($urandom_range(0, 2) == 0) begin
            neg  = $urandom_range(1, 1024);
            succ = LINK_W'(-neg);
          end else begin
            succ = -11'sd1;
          end
          load_node(addrs[i], VALUE_W'($urandom()), succ);
        end
        runs = $urandom_range(1, 3);
        for (i = 0; i < runs; i++) begin
          case ($urandom_range(0, 9))
            0: k = 7'd0;
            1: k = GROUP_W'($urandom_range(64, 127));
            default: k = GROUP_W'($urandom_range(1, (len < 63) ? len + 1 : 64));
          endcase
          a = ($urandom_range(0, 3) == 0) ? addrs[$urandom_range(0, len - 1)] : addrs[0];
          run_list(a, 1'b0, k);
        end
      end else if (choice == 7) begin
        load_node(ADDR_W'($urandom_range(0, 1023)), VALUE_W'($urandom()),
                  LINK_W'($urandom_range(0, 2047)));
      end else if (choice == 8) begin
        run_list(ADDR_W'($urandom_range(0, 1023)), 1'b1, GROUP_W'($urandom_range(0, 127)));
      end else if (written_addrs.size() != 0) begin
        a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        if (walk_stays_written(a)) run_list(a, 1'b0, GROUP_W'($urandom_range(0, 127)));
      end
    end
  endtask

  // result side stalls
  always @(negedge clk_i) begin
    if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
      pop      <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      pop_hold <= $urandom_range(0, 15);
      pop      <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word, address %0d", out_address_o));
        end else begin
          want = expected_words.pop_front();
          if (out_address_o !== want.addr)
            report_mismatch($sformatf("address got %0d exp %0d", out_address_o, want.addr));
          if (out_value_o !== want.value)
            report_mismatch($sformatf("value got %0d exp %0d", out_value_o, want.value));
          if (out_successor_o !== want.succ)
            report_mismatch($sformatf("successor got %0d exp %0d", out_successor_o,
                                      want.succ));
          if (last_o !== want.last)
            report_mismatch($sformatf("last got %b exp %b", last_o, want.last));
          if (empty_res_o !== want.empty_res)
            report_mismatch($sformatf("empty_res got %b exp %b", empty_res_o,
                                      want.empty_res));
          if (truncated_o !== want.trunc)
            report_mismatch($sformatf("truncated got %b exp %b", truncated_o, want.trunc));
        end
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_single_node();
    test_group_reversal();
    test_negative_successor();
    test_walk_limit();
    test_random_traffic();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
